### rtl/core/aprlm_pkg.sv
// aprlm_pkg: shared widths, register map, config and control structs
// for the audio peak / RMS level meter. No dependencies.
`timescale 1ns / 1ps

package aprlm_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int CHAN_W       = 3;
  localparam int POS_W        = 2;
  localparam int PICK_W       = 2;
  localparam int MAX_CHANNELS = 4;
  localparam int COUNT_W      = 32;
  localparam int ENERGY_W     = 62;   // (2^32-1) * 2^30 < 2^62
  localparam int SQUARE_W     = 31;   // 32768^2 = 2^30
  localparam int QUOT_W       = 31;   // mean square never exceeds 2^30
  localparam int LEVEL_W      = 16;
  localparam int DIV_STEPS    = ENERGY_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam int SQRT_STEPS   = (QUOT_W + 1) / 2;
  localparam int SQRT_CNT_W   = $clog2(SQRT_STEPS);

  localparam logic [LEVEL_W-1:0] SILENCE_RESET = LEVEL_W'(200);

  // APB register map
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam logic [1:0] REG_CHANNEL_COUNT     = 2'd0;
  localparam logic [1:0] REG_PICKED_CHANNEL    = 2'd1;
  localparam logic [1:0] REG_SILENCE_THRESHOLD = 2'd2;

  typedef struct packed {
    logic [CHAN_W-1:0]  channel_count;
    logic [PICK_W-1:0]  picked_channel;
    logic [LEVEL_W-1:0] silence_threshold;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic square;
    logic accum;
    logic rms_zero;
    logic div_start;
    logic sqrt_start;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic kept;
    logic last;
    logic count_zero;
    logic div_done;
    logic sqrt_done;
    logic out_free;
  } stat_t;

endpackage

### rtl/core/aprlm_pcm_if.sv
// aprlm_pcm_if: valid/ready channel carrying one interleaved PCM sample.
// Depends on aprlm_pkg for widths.
`timescale 1ns / 1ps

interface aprlm_pcm_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [aprlm_pkg::SAMPLE_W-1:0] pcm_sample;
  logic                                  last_sample;

  modport source(output valid, pcm_sample, last_sample, input ready);
  modport sink(input valid, pcm_sample, last_sample, output ready);
endinterface

### rtl/core/aprlm_level_if.sv
// aprlm_level_if: valid/ready channel carrying one mono sample / level report.
// Depends on aprlm_pkg for widths.
`timescale 1ns / 1ps

interface aprlm_level_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  sample_valid;
  logic signed [aprlm_pkg::SAMPLE_W-1:0] mono_sample;
  logic                                  report_valid;
  logic [aprlm_pkg::LEVEL_W-1:0]         peak_level;
  logic [aprlm_pkg::LEVEL_W-1:0]         rms_level;
  logic                                  silent;

  modport source(output valid, sample_valid, mono_sample, report_valid,
                 peak_level, rms_level, silent, input ready);
  modport sink(input valid, sample_valid, mono_sample, report_valid,
               peak_level, rms_level, silent, output ready);
endinterface

### rtl/core/aprlm_cfg.sv
// aprlm_cfg: APB register file for channel count, picked channel and
// silence threshold. Depends on aprlm_pkg.
`timescale 1ns / 1ps

module aprlm_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [aprlm_pkg::ADDR_W-1:0]   paddr,
  input  logic [aprlm_pkg::DATA_W-1:0]   pwdata,
  output logic [aprlm_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  output aprlm_pkg::cfg_t                cfg
);
  import aprlm_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.channel_count     <= CHAN_W'(1);
      cfg.picked_channel    <= '0;
      cfg.silence_threshold <= SILENCE_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_CHANNEL_COUNT:     cfg.channel_count     <= pwdata[CHAN_W-1:0];
        REG_PICKED_CHANNEL:    cfg.picked_channel    <= pwdata[PICK_W-1:0];
        REG_SILENCE_THRESHOLD: cfg.silence_threshold <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_CHANNEL_COUNT:     prdata = DATA_W'(cfg.channel_count);
      REG_PICKED_CHANNEL:    prdata = DATA_W'(cfg.picked_channel);
      REG_SILENCE_THRESHOLD: prdata = DATA_W'(cfg.silence_threshold);
      default:               prdata = '0;
    endcase
  end

endmodule

### rtl/core/aprlm_div.sv
// aprlm_div: restoring divider, one quotient bit per cycle, energy / count.
// Depends on aprlm_pkg. Quotient is valid when done pulses.
`timescale 1ns / 1ps

module aprlm_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [aprlm_pkg::ENERGY_W-1:0]  dividend,
  input  logic [aprlm_pkg::COUNT_W-1:0]   divisor,
  output logic [aprlm_pkg::QUOT_W-1:0]    quotient,
  output logic                            done
);
  import aprlm_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] step;
  logic [COUNT_W-1:0]   rem;
  logic [ENERGY_W-1:0]  work;
  logic [COUNT_W:0]     rem_sh;
  logic                 q_bit;
  logic [COUNT_W-1:0]   rem_next;

  assign rem_sh   = {rem, work[ENERGY_W-1]};
  assign q_bit    = rem_sh >= {1'b0, divisor};
  assign rem_next = q_bit ? COUNT_W'(rem_sh - {1'b0, divisor}) : rem_sh[COUNT_W-1:0];
  assign quotient = work[QUOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      work <= dividend;
    end else if (busy) begin
      rem  <= rem_next;
      work <= {work[ENERGY_W-2:0], q_bit};
    end
  end

endmodule

### rtl/core/aprlm_sqrt.sv
// aprlm_sqrt: digit-by-digit integer square root, one result bit per cycle.
// Depends on aprlm_pkg. Root is valid when done pulses.
`timescale 1ns / 1ps

module aprlm_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [aprlm_pkg::QUOT_W-1:0]   value,
  output logic [aprlm_pkg::LEVEL_W-1:0]  root_out,
  output logic                           done
);
  import aprlm_pkg::*;

  logic                  busy;
  logic [SQRT_CNT_W-1:0] step;
  logic [QUOT_W-1:0]     rest;
  logic [QUOT_W-1:0]     root;
  logic [QUOT_W-1:0]     bitv;
  logic [QUOT_W:0]       trial;
  logic                  take;

  assign trial    = {1'b0, root} + {1'b0, bitv};
  assign take     = {1'b0, rest} >= trial;
  assign root_out = root[LEVEL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rest <= value;
      root <= '0;
      bitv <= QUOT_W'(1) << (QUOT_W - 1);
    end else if (busy) begin
      if (take) begin
        rest <= QUOT_W'({1'b0, rest} - trial);
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

### rtl/core/aprlm_dp.sv
// aprlm_dp: sample capture, channel walk, peak / energy / count accumulators,
// report math (divider, square root) and the output register.
// Depends on aprlm_pkg, aprlm_div, aprlm_sqrt.
`timescale 1ns / 1ps

module aprlm_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  aprlm_pkg::cfg_t                       cfg,
  input  aprlm_pkg::cmd_t                       cmd,
  output aprlm_pkg::stat_t                      stat,
  input  logic signed [aprlm_pkg::SAMPLE_W-1:0] pcm_sample,
  input  logic                                  last_sample,
  input  logic                                  out_ready,
  output logic                                  out_valid,
  output logic                                  sample_valid,
  output logic signed [aprlm_pkg::SAMPLE_W-1:0] mono_sample,
  output logic                                  report_valid,
  output logic [aprlm_pkg::LEVEL_W-1:0]         peak_level,
  output logic [aprlm_pkg::LEVEL_W-1:0]         rms_level,
  output logic                                  silent
);
  import aprlm_pkg::*;

  logic [POS_W-1:0]           pos;
  logic [CHAN_W-1:0]          chans;
  logic [POS_W-1:0]           pos_eff;
  logic [CHAN_W-1:0]          pos_inc;
  logic [POS_W-1:0]           pos_next;
  logic                       kept_c;

  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;
  logic                       kept;
  logic [SAMPLE_W-1:0]        mag;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [SQUARE_W-1:0]        square;

  logic [LEVEL_W-1:0]         peak;
  logic [ENERGY_W-1:0]        energy;
  logic [COUNT_W-1:0]         count;
  logic [LEVEL_W-1:0]         rms;

  logic [QUOT_W-1:0]          quotient;
  logic [LEVEL_W-1:0]         root;
  logic                       div_done;
  logic                       sqrt_done;

  // channel walk; out-of-range counts clamp to 1..MAX_CHANNELS
  always_comb begin
    if (cfg.channel_count == '0) begin
      chans = CHAN_W'(1);
    end else if (cfg.channel_count > CHAN_W'(MAX_CHANNELS)) begin
      chans = CHAN_W'(MAX_CHANNELS);
    end else begin
      chans = cfg.channel_count;
    end
    pos_eff  = ({1'b0, pos} >= chans) ? '0 : pos;
    pos_inc  = {1'b0, pos_eff} + CHAN_W'(1);
    pos_next = (pos_inc >= chans) ? '0 : pos_inc[POS_W-1:0];
    kept_c   = pos_eff == cfg.picked_channel;
  end

  // -32768 maps to 0x8000, which reads as 32768 unsigned
  assign mag     = sample[SAMPLE_W-1] ? SAMPLE_W'(SAMPLE_W'(0) - sample) : sample;
  assign sq_full = sample * sample;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= pcm_sample;
      last   <= last_sample;
      kept   <= kept_c;
    end
    if (cmd.square) begin
      square <= sq_full[SQUARE_W-1:0];
    end
    if (cmd.rms_zero) begin
      rms <= '0;
    end else if (sqrt_done) begin
      rms <= root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      peak   <= '0;
      energy <= '0;
      count  <= '0;
    end else begin
      if (cmd.load) begin
        pos <= last_sample ? '0 : pos_next;
      end
      if (cmd.accum && kept) begin
        if (mag > peak) begin
          peak <= mag;
        end
        if (count != {COUNT_W{1'b1}}) begin
          energy <= energy + ENERGY_W'(square);
          count  <= count + 1'b1;
        end
      end
      if (cmd.emit && last) begin
        peak   <= '0;
        energy <= '0;
        count  <= '0;
      end
    end
  end

  // output register: holds one result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_valid <= kept;
      mono_sample  <= kept ? sample : '0;
      report_valid <= last;
      peak_level   <= last ? peak : '0;
      rms_level    <= last ? rms : '0;
      silent       <= last && (peak < cfg.silence_threshold);
    end
  end

  aprlm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (energy),
    .divisor  (count),
    .quotient (quotient),
    .done     (div_done)
  );

  aprlm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.sqrt_start),
    .value    (quotient),
    .root_out (root),
    .done     (sqrt_done)
  );

  assign stat.kept       = kept;
  assign stat.last       = last;
  assign stat.count_zero = count == '0;
  assign stat.div_done   = div_done;
  assign stat.sqrt_done  = sqrt_done;
  assign stat.out_free   = !out_valid || out_ready;

endmodule

### rtl/core/aprlm_ctrl.sv
// aprlm_ctrl: sequencer for one item at a time: capture, square, accumulate,
// optional report math, and hand-off to the output register unless dropped.
// Depends on aprlm_pkg.
`timescale 1ns / 1ps

module aprlm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  aprlm_pkg::stat_t  stat,
  output aprlm_pkg::cmd_t   cmd
);
  import aprlm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_SQRT = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SQ;
        end
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        if (stat.last) begin
          state_next = S_CHK;
        end else if (stat.kept) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_CHK: begin
        // empty recording: skip the divide, rms reads zero
        if (stat.count_zero) begin
          cmd.rms_zero = 1'b1;
          state_next   = S_EMIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.sqrt_start = 1'b1;
          state_next     = S_SQRT;
        end
      end
      S_SQRT: begin
        if (stat.sqrt_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/audio_peak_rms_level_meter.sv
// audio_peak_rms_level_meter: top level of the PCM peak / RMS level meter.
// Depends on aprlm_pkg, aprlm_pcm_if, aprlm_level_if, aprlm_cfg, aprlm_ctrl, aprlm_dp.
//
//   channel  role    payload
//   pcm      sink    pcm_sample, last_sample
//   level    source  sample_valid, mono_sample, report_valid, peak_level,
//                    rms_level, silent
//   apb      slave   channel_count @0x0, picked_channel @0x4,
//                    silence_threshold @0x8
//
// One item at a time: capture, square and accumulate for a dropped sample, plus the
// hand-off for a kept one. A last item adds the report math: a check, the divider and
// the square root; an empty recording skips the divider and the square root.
// A stalled level sink holds the item in the hand-off state; the output register
// keeps the previous result meanwhile.
// rst is synchronous; it clears the accumulators, channel position and registers.
`timescale 1ns / 1ps

module audio_peak_rms_level_meter (
  input  logic                         clk,
  input  logic                         rst,
  aprlm_pcm_if.sink                    pcm,
  aprlm_level_if.source                level,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [aprlm_pkg::ADDR_W-1:0] paddr,
  input  logic [aprlm_pkg::DATA_W-1:0] pwdata,
  output logic [aprlm_pkg::DATA_W-1:0] prdata,
  output logic                         pready
);
  import aprlm_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  aprlm_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  aprlm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pcm.valid),
    .in_ready (pcm.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  aprlm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cmd          (cmd),
    .stat         (stat),
    .pcm_sample   (pcm.pcm_sample),
    .last_sample  (pcm.last_sample),
    .out_ready    (level.ready),
    .out_valid    (level.valid),
    .sample_valid (level.sample_valid),
    .mono_sample  (level.mono_sample),
    .report_valid (level.report_valid),
    .peak_level   (level.peak_level),
    .rms_level    (level.rms_level),
    .silent       (level.silent)
  );

  // one item in flight: no second transfer right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (pcm.valid && pcm.ready) |=> !pcm.ready)
    else $error("input accepted twice in a row");

  // every result carries a sample, a report, or both
  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    level.valid |-> (level.sample_valid || level.report_valid))
    else $error("empty result presented");

  // level fields stay zero on a sample-only result
  a_report_fields: assert property (@(posedge clk) disable iff (rst)
    (level.valid && !level.report_valid) |->
      (level.peak_level == '0 && level.rms_level == '0 && !level.silent))
    else $error("level fields set without report");

  // rms never exceeds peak
  a_rms_le_peak: assert property (@(posedge clk) disable iff (rst)
    (level.valid && level.report_valid) |-> (level.rms_level <= level.peak_level))
    else $error("rms above peak");

endmodule
